/* hw/rtl/rc5_pkg.sv */
// ----------------------------------------------------------------------------
// rc5 frame decoder package
// shared types, register codes and reset values of the rc5 decoder
// ----------------------------------------------------------------------------
package rc5_pkg;

    localparam int unsigned FINE_W   = 8;
    localparam int unsigned SEARCH_W = 16;
    localparam int unsigned BITS_W   = 4;
    localparam int unsigned FRAME_W  = 12;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned CMD_W    = 6;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned IDX_W    = 2;

    localparam logic [BITS_W-1:0]   FRAME_BITS = 4'd12;
    localparam logic [FINE_W-1:0]   FINE_MAX   = 8'hFF;
    localparam logic [SEARCH_W-1:0] SEARCH_MAX = 16'hFFFF;

    localparam logic [FINE_W-1:0]   QUIET_RST    = 8'd55;
    localparam logic [SEARCH_W-1:0] TIMEOUT_RST  = 16'd2048;
    localparam logic [FINE_W-1:0]   MAX_HALF_RST = 8'd17;

    // register index codes
    localparam logic [IDX_W-1:0] CFG_QUIET    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_TIMEOUT  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MAX_HALF = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_QUIET  = 3'd1,
        PH_LEAD   = 3'd2,
        PH_HALF   = 3'd3,
        PH_START2 = 3'd4,
        PH_SAMPLE = 3'd5,
        PH_SYNC   = 3'd6
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [FINE_W-1:0]   fine_count;
        logic [SEARCH_W-1:0] search_count;
        logic [FINE_W-1:0]   three_quarter_mark;
        logic [FINE_W-1:0]   five_quarter_mark;
        logic [BITS_W-1:0]   bits_left;
        logic [FRAME_W-1:0]  shift_bits;
        logic                sampled_bit;
        logic                previous_pin;
        logic                edge_pending;
    } t_dec_state;

    typedef struct packed {
        logic [FINE_W-1:0]   quiet_ticks;
        logic [SEARCH_W-1:0] search_timeout_ticks;
        logic [FINE_W-1:0]   max_half_bit_ticks;
    } t_dec_cfg;

    typedef struct packed {
        logic              valid;
        logic              frame_error;
        logic              toggle_bit;
        logic [ADDR_W-1:0] device_address;
        logic [CMD_W-1:0]  command_code;
    } t_dec_result;

endpackage

/* hw/rtl/rc5_step.sv */
// ----------------------------------------------------------------------------
// rc5 decoder step
// next state and result of the frame decoder for one pin sample
// ----------------------------------------------------------------------------
module rc5_step (
    input  rc5_pkg::t_dec_state  i_state,
    input  rc5_pkg::t_dec_cfg    i_cfg,
    input  logic                 i_pin,
    output rc5_pkg::t_dec_state  o_state,
    output rc5_pkg::t_dec_result o_result
);

    logic                         fall;
    logic                         active;
    logic                         do_lead;
    logic                         do_sync;
    logic                         fin;
    logic                         fin_err;
    logic                         smp;
    logic [rc5_pkg::FINE_W-1:0]   fc;
    logic [rc5_pkg::SEARCH_W-1:0] sc;
    logic [rc5_pkg::FINE_W+1:0]   m3;
    logic [rc5_pkg::FINE_W+2:0]   m5;
    logic [rc5_pkg::FINE_W:0]     m3_half;
    logic [rc5_pkg::FINE_W+1:0]   m5_half;

    assign fall = i_state.previous_pin & ~i_pin;
    assign fc   = (i_state.fine_count == rc5_pkg::FINE_MAX) ?
                  i_state.fine_count : i_state.fine_count + 1'b1;
    assign sc   = (i_state.search_count == rc5_pkg::SEARCH_MAX) ?
                  i_state.search_count : i_state.search_count + 1'b1;
    assign m3      = {2'b00, fc} * 10'd3;
    assign m5      = {3'b000, fc} * 11'd5;
    assign m3_half = m3[rc5_pkg::FINE_W+1:1];
    assign m5_half = m5[rc5_pkg::FINE_W+2:1];

    always_comb begin
        unique case (i_state.phase)
            rc5_pkg::PH_QUIET, rc5_pkg::PH_LEAD, rc5_pkg::PH_HALF,
            rc5_pkg::PH_START2, rc5_pkg::PH_SAMPLE, rc5_pkg::PH_SYNC: active = 1'b1;
            default: active = 1'b0;
        endcase
    end

    always_comb begin
        o_state              = i_state;
        o_state.previous_pin = i_pin;
        do_lead              = 1'b0;
        do_sync              = 1'b0;
        fin                  = 1'b0;
        fin_err              = 1'b0;
        smp                  = i_state.sampled_bit;
        if (!active) begin
            o_state.phase = rc5_pkg::PH_IDLE;
            if (fall) begin
                o_state.phase        = rc5_pkg::PH_QUIET;
                o_state.fine_count   = '0;
                o_state.search_count = '0;
            end
        end else begin
            if (fall) begin
                o_state.edge_pending = 1'b1;
            end
            o_state.fine_count   = fc;
            o_state.search_count = sc;
            case (i_state.phase)
                rc5_pkg::PH_QUIET: begin
                    if (sc >= i_cfg.search_timeout_ticks) begin
                        fin     = 1'b1;
                        fin_err = 1'b1;
                    end else if (fc >= i_cfg.quiet_ticks) begin
                        o_state.phase = rc5_pkg::PH_LEAD;
                        do_lead       = 1'b1;
                    end else if (!i_pin) begin
                        o_state.fine_count = '0;
                    end
                end
                rc5_pkg::PH_LEAD: begin
                    do_lead = 1'b1;
                end
                rc5_pkg::PH_HALF: begin
                    if (fc >= i_cfg.max_half_bit_ticks) begin
                        fin     = 1'b1;
                        fin_err = 1'b1;
                    end else if (i_pin) begin
                        o_state.three_quarter_mark = (m3_half > 9'd255) ?
                            rc5_pkg::FINE_MAX : m3_half[rc5_pkg::FINE_W-1:0];
                        o_state.five_quarter_mark  = (m5_half > 10'd255) ?
                            rc5_pkg::FINE_MAX : m5_half[rc5_pkg::FINE_W-1:0];
                        o_state.fine_count = '0;
                        o_state.phase      = rc5_pkg::PH_START2;
                    end
                end
                rc5_pkg::PH_START2: begin
                    if (fc >= i_state.three_quarter_mark) begin
                        fin     = 1'b1;
                        fin_err = 1'b1;
                    end else if (!i_pin) begin
                        o_state.fine_count = '0;
                        o_state.bits_left  = rc5_pkg::FRAME_BITS;
                        o_state.shift_bits = '0;
                        o_state.phase      = rc5_pkg::PH_SAMPLE;
                    end
                end
                rc5_pkg::PH_SAMPLE: begin
                    if (fc > i_state.three_quarter_mark || fc == rc5_pkg::FINE_MAX) begin
                        smp                 = i_pin;
                        o_state.sampled_bit = i_pin;
                        o_state.shift_bits  = {i_state.shift_bits[rc5_pkg::FRAME_W-2:0], i_pin};
                        o_state.phase       = rc5_pkg::PH_SYNC;
                        do_sync             = 1'b1;
                    end
                end
                rc5_pkg::PH_SYNC: begin
                    do_sync = 1'b1;
                end
                default: begin
                end
            endcase

            if (do_lead) begin
                if (sc >= i_cfg.search_timeout_ticks) begin
                    fin     = 1'b1;
                    fin_err = 1'b1;
                end else if (!i_pin) begin
                    o_state.fine_count = '0;
                    o_state.phase      = rc5_pkg::PH_HALF;
                end
            end

            if (do_sync) begin
                if (fc >= i_state.five_quarter_mark) begin
                    fin     = 1'b1;
                    fin_err = 1'b1;
                end else if (i_pin != smp) begin
                    o_state.fine_count = '0;
                    if (i_state.bits_left <= 4'd1) begin
                        o_state.bits_left = '0;
                        fin               = 1'b1;
                    end else begin
                        o_state.bits_left = i_state.bits_left - 1'b1;
                        o_state.phase     = rc5_pkg::PH_SAMPLE;
                    end
                end
            end

            // a latched edge restarts the search right after the result
            if (fin) begin
                if (o_state.edge_pending) begin
                    o_state.phase        = rc5_pkg::PH_QUIET;
                    o_state.fine_count   = '0;
                    o_state.search_count = '0;
                end else begin
                    o_state.phase = rc5_pkg::PH_IDLE;
                end
                o_state.edge_pending = 1'b0;
            end
        end
    end

    always_comb begin
        o_result.valid          = fin;
        o_result.frame_error    = fin_err;
        o_result.toggle_bit     = 1'b0;
        o_result.device_address = '0;
        o_result.command_code   = '0;
        if (!fin_err) begin
            o_result.toggle_bit     = o_state.shift_bits[rc5_pkg::FRAME_W-1];
            o_result.device_address = o_state.shift_bits[rc5_pkg::FRAME_W-2:rc5_pkg::CMD_W];
            o_result.command_code   = o_state.shift_bits[rc5_pkg::CMD_W-1:0];
        end
    end

endmodule

/* hw/rtl/rc5_ir_frame_decoder.sv */
// ----------------------------------------------------------------------------
// rc5 ir frame decoder
// decodes rc5 frames from one demodulated receiver sample per tick
// ----------------------------------------------------------------------------
// The block takes one pin sample per clock cycle on the input stream and
// gives one item per finished frame on the output stream, in the cycle after
// the sample that ends the frame: either the toggle bit, address and command,
// or an error flag in tuser with all data bits zero. The decoder state is
// updated once per accepted sample, so a sample can be accepted every cycle;
// the input stalls only while a finished result sits in the output register
// and the sink does not take it. The user must write registers on the plain
// config port only while no frame is in progress; this is not enforced.
// ----------------------------------------------------------------------------
module rc5_ir_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] pin_level, [7:1] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [0] toggle_bit, [5:1] device_address,
                                          // [11:6] command_code, [15:12] zero
    output logic        o_m_axis_tuser,   // [0] frame_error
    input  logic        i_cfg_we,
    input  logic [rc5_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [rc5_pkg::CFG_W-1:0] i_cfg_data
);

    rc5_pkg::t_dec_state  r_state;
    rc5_pkg::t_dec_state  n_state;
    rc5_pkg::t_dec_cfg    r_cfg;
    rc5_pkg::t_dec_result n_result;
    logic                 r_out_valid;
    logic                 r_out_err;
    logic [11:0]          r_out_data;
    logic                 w_in_accept;

    assign o_s_axis_tready = ~r_out_valid | i_m_axis_tready;
    assign w_in_accept     = i_s_axis_tvalid & o_s_axis_tready;

    rc5_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_pin    (i_s_axis_tdata[0]),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quiet_ticks          <= rc5_pkg::QUIET_RST;
            r_cfg.search_timeout_ticks <= rc5_pkg::TIMEOUT_RST;
            r_cfg.max_half_bit_ticks   <= rc5_pkg::MAX_HALF_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rc5_pkg::CFG_QUIET:    r_cfg.quiet_ticks <= i_cfg_data[rc5_pkg::FINE_W-1:0];
                rc5_pkg::CFG_TIMEOUT:  r_cfg.search_timeout_ticks <= i_cfg_data;
                rc5_pkg::CFG_MAX_HALF: r_cfg.max_half_bit_ticks <=
                                           i_cfg_data[rc5_pkg::FINE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase              <= rc5_pkg::PH_IDLE;
            r_state.fine_count         <= '0;
            r_state.search_count       <= '0;
            r_state.three_quarter_mark <= '0;
            r_state.five_quarter_mark  <= '0;
            r_state.bits_left          <= '0;
            r_state.shift_bits         <= '0;
            r_state.sampled_bit        <= 1'b0;
            r_state.previous_pin       <= 1'b1;
            r_state.edge_pending       <= 1'b0;
        end else if (w_in_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= n_result.valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && n_result.valid) begin
            r_out_err  <= n_result.frame_error;
            r_out_data <= {n_result.command_code, n_result.device_address,
                           n_result.toggle_bit};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_err;
    assign o_m_axis_tdata  = {4'b0000, r_out_data};

`ifndef SYNTHESIS
    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_err |-> r_out_data == 12'd0)
        else $error("error item carries nonzero data");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input accepted while result stalled");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == rc5_pkg::PH_IDLE |-> !r_state.edge_pending)
        else $error("pending edge left while idle");

    a_bits_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bits_left <= rc5_pkg::FRAME_BITS)
        else $error("bit count out of range");

    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_in_accept))
        else $error("result without an accepted item");
`endif

endmodule

/* dv/rc5_ir_frame_decoder_tb.sv */
// ----------------------------------------------------------------------------
// rc5 ir frame decoder testbench
// drives pin samples shaped as rc5 frames, clean and flawed, through several
// register settings and compares every decoded frame against an in-bench
// model of the decoder, with random stalls on both streams
// ----------------------------------------------------------------------------
module rc5_ir_frame_decoder_tb;
    import rc5_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int PLAN_COUNT  = 8;

    typedef enum int {
        FLAW_NONE        = 0,
        FLAW_LONG_HALF   = 1,
        FLAW_LATE_START2 = 2,
        FLAW_NO_MID_EDGE = 3,
        FLAW_STRETCH     = 4,
        FLAW_TRUNCATE    = 5,
        FLAW_STUCK_HIGH  = 6,
        FLAW_NOISE       = 7
    } t_flaw;

    class rc5_frame_scoreboard;
        t_dec_cfg    regs;
        t_dec_state  st;
        t_dec_result frames_due[$];
        int          frames_predicted;
        int          mismatches;

        function new();
            regs.quiet_ticks          = QUIET_RST;
            regs.search_timeout_ticks = TIMEOUT_RST;
            regs.max_half_bit_ticks   = MAX_HALF_RST;
            st                        = '0;
            st.phase                  = PH_IDLE;
            st.previous_pin           = 1'b1;
            frames_predicted          = 0;
            mismatches                = 0;
        endfunction

        function void apply_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_QUIET:    regs.quiet_ticks          = val[FINE_W-1:0];
                CFG_TIMEOUT:  regs.search_timeout_ticks = val;
                CFG_MAX_HALF: regs.max_half_bit_ticks   = val[FINE_W-1:0];
                default: ;
            endcase
        endfunction

        function int count_due();
            return frames_due.size();
        endfunction

        function bit busy();
            return st.phase != PH_IDLE;
        endfunction

        function void close_frame(bit err);
            t_dec_result r;
            r.valid          = 1'b1;
            r.frame_error    = err;
            r.toggle_bit     = err ? 1'b0 : st.shift_bits[11];
            r.device_address = err ? '0 : st.shift_bits[10:6];
            r.command_code   = err ? '0 : st.shift_bits[5:0];
            frames_due.push_back(r);
            frames_predicted++;
            if (st.edge_pending) begin
                st.phase        = PH_QUIET;
                st.fine_count   = '0;
                st.search_count = '0;
            end else begin
                st.phase = PH_IDLE;
            end
            st.edge_pending = 1'b0;
        endfunction

        function void take_pin_sample(logic pin);
            logic fall;
            int   mark;
            fall            = st.previous_pin && !pin;
            st.previous_pin = pin;
            if (st.phase == PH_IDLE || st.phase > PH_SYNC) begin
                st.phase = PH_IDLE;
                if (fall) begin
                    st.phase        = PH_QUIET;
                    st.fine_count   = '0;
                    st.search_count = '0;
                end
                return;
            end
            if (fall) st.edge_pending = 1'b1;
            if (st.fine_count != FINE_MAX) st.fine_count = st.fine_count + 1'b1;
            if (st.search_count != SEARCH_MAX) st.search_count = st.search_count + 1'b1;

            if (st.phase == PH_QUIET) begin
                if (st.search_count >= regs.search_timeout_ticks) begin
                    close_frame(1'b1);
                    return;
                end
                if (st.fine_count >= regs.quiet_ticks) begin
                    st.phase = PH_LEAD;
                end else begin
                    if (!pin) st.fine_count = '0;
                    return;
                end
            end
            if (st.phase == PH_LEAD) begin
                if (st.search_count >= regs.search_timeout_ticks) begin
                    close_frame(1'b1);
                    return;
                end
                if (!pin) begin
                    st.fine_count = '0;
                    st.phase      = PH_HALF;
                end
                return;
            end
            if (st.phase == PH_HALF) begin
                if (st.fine_count >= regs.max_half_bit_ticks) begin
                    close_frame(1'b1);
                    return;
                end
                if (pin) begin
                    mark = int'(st.fine_count) * 3 / 2;
                    st.three_quarter_mark = (mark > 255) ? FINE_MAX : FINE_W'(mark);
                    mark = int'(st.fine_count) * 5 / 2;
                    st.five_quarter_mark = (mark > 255) ? FINE_MAX : FINE_W'(mark);
                    st.fine_count = '0;
                    st.phase      = PH_START2;
                end
                return;
            end
            if (st.phase == PH_START2) begin
                if (st.fine_count >= st.three_quarter_mark) begin
                    close_frame(1'b1);
                    return;
                end
                if (!pin) begin
                    st.fine_count = '0;
                    st.bits_left  = FRAME_BITS;
                    st.shift_bits = '0;
                    st.phase      = PH_SAMPLE;
                end
                return;
            end
            if (st.phase == PH_SAMPLE) begin
                if (st.fine_count <= st.three_quarter_mark && st.fine_count != FINE_MAX)
                    return;
                st.sampled_bit = pin;
                st.shift_bits  = {st.shift_bits[FRAME_W-2:0], pin};
                st.phase       = PH_SYNC;
            end
            // waiting for the mid-bit edge
            if (st.fine_count >= st.five_quarter_mark) begin
                close_frame(1'b1);
                return;
            end
            if (pin != st.sampled_bit) begin
                st.fine_count = '0;
                if (st.bits_left <= 1) begin
                    st.bits_left = '0;
                    close_frame(1'b0);
                    return;
                end
                st.bits_left = st.bits_left - 1'b1;
                st.phase     = PH_SAMPLE;
            end
        endfunction

        function void check_frame(logic err_flag, logic [15:0] data);
            t_dec_result want;
            if (frames_due.size() == 0) begin
                $display("%0t unexpected frame: actual error %0d data 0x%h",
                         $time, err_flag, data);
                mismatches++;
                return;
            end
            want = frames_due.pop_front();
            if (want.frame_error != err_flag) begin
                $display("%0t frame_error: expected %0d actual %0d",
                         $time, want.frame_error, err_flag);
                mismatches++;
            end
            if (want.toggle_bit != data[0]) begin
                $display("%0t toggle_bit: expected %0d actual %0d",
                         $time, want.toggle_bit, data[0]);
                mismatches++;
            end
            if (want.device_address != data[5:1]) begin
                $display("%0t device_address: expected %0d actual %0d",
                         $time, want.device_address, data[5:1]);
                mismatches++;
            end
            if (want.command_code != data[11:6]) begin
                $display("%0t command_code: expected %0d actual %0d",
                         $time, want.command_code, data[11:6]);
                mismatches++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_axis_tvalid;
    logic               o_s_axis_tready;
    logic [7:0]         i_s_axis_tdata;    // [0] pin_level, [7:1] zero
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready;
    logic [15:0]        o_m_axis_tdata;    // [0] toggle_bit, [5:1] device_address,
                                           // [11:6] command_code, [15:12] zero
    logic               o_m_axis_tuser;    // [0] frame_error
    logic               i_cfg_we;
    logic [IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;

    rc5_frame_scoreboard sb;
    bit                  steady;
    int                  hold_cycles;
    int                  items_sent;

    rc5_ir_frame_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // sink side: random stall per item, one long hold when asked
    initial begin : frame_sink
        int stall;
        i_m_axis_tready <= 1'b0;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_frame(o_m_axis_tuser, o_m_axis_tdata);
    end

    task automatic send_sample(input logic lvl);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, lvl};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.take_pin_sample(lvl);
        items_sent++;
    endtask

    task automatic send_level(input logic lvl, input int count);
        for (int i = 0; i < count; i++) send_sample(lvl);
    endtask

    task automatic send_frame(input int half, input logic [11:0] bits, input t_flaw flaw);
        int spot;
        int first_len;
        int second_len;
        int lead_len;
        int rise_len;
        spot = $urandom_range(0, 11);
        send_level(1'b0, $urandom_range(1, 3));
        if (flaw == FLAW_NOISE) begin
            for (int i = $urandom_range(1, 40); i > 0; i--) send_sample($urandom_range(0, 1));
            return;
        end
        send_level(1'b1, int'(sb.regs.quiet_ticks) + 1 + $urandom_range(0, 6));
        if (flaw == FLAW_STUCK_HIGH) begin
            if (sb.regs.search_timeout_ticks <= 1000)
                send_level(1'b1, int'(sb.regs.search_timeout_ticks) + 4);
            return;
        end
        lead_len = half;
        if (flaw == FLAW_LONG_HALF)
            lead_len = int'(sb.regs.max_half_bit_ticks) + $urandom_range(1, 3);
        rise_len = (flaw == FLAW_LATE_START2) ? 2 * half + 1 : half;
        send_level(1'b0, lead_len);
        send_level(1'b1, rise_len);
        send_level(1'b0, half);
        for (int i = 11; i >= 0; i--) begin
            if (flaw == FLAW_TRUNCATE && i == spot) return;
            first_len  = half;
            second_len = half;
            if (flaw == FLAW_STRETCH && i == spot) first_len += $urandom_range(1, half);
            send_level(bits[i], first_len);
            send_level((flaw == FLAW_NO_MID_EDGE && i == spot) ? bits[i] : !bits[i],
                       second_len);
        end
    endtask

    // hold the pin high until the decoder has given up on any frame, then let
    // every expected item drain before touching the registers
    task automatic settle();
        while (sb.busy()) send_sample(1'b1);
        i_s_axis_tvalid <= 1'b0;
        while (sb.count_due() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_regs(input int quiet, input int timeout, input int max_half);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_QUIET;
        i_cfg_data  <= CFG_W'(quiet);
        @(posedge i_clk);
        i_cfg_index <= CFG_TIMEOUT;
        i_cfg_data  <= CFG_W'(timeout);
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_HALF;
        i_cfg_data  <= CFG_W'(max_half);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.apply_reg(CFG_QUIET, CFG_W'(quiet));
        sb.apply_reg(CFG_TIMEOUT, CFG_W'(timeout));
        sb.apply_reg(CFG_MAX_HALF, CFG_W'(max_half));
    endtask

    task automatic run_random_frames();
        int frames_at_start;
        int items_at_start;
        int sent;
        int hi;
        int half;
        t_flaw flaw;
        frames_at_start = sb.frames_predicted;
        items_at_start  = items_sent;
        sent            = 0;
        while ((sb.frames_predicted - frames_at_start < 8 || items_sent - items_at_start < 240)
               && sent < 60) begin
            hi = int'(sb.regs.max_half_bit_ticks) - 1;
            if (hi > 8) hi = 8;
            half = (hi >= 3) ? $urandom_range(3, hi) : $urandom_range(1, 4);
            flaw = FLAW_NONE;
            if ($urandom_range(0, 99) >= 75) flaw = t_flaw'($urandom_range(1, 7));
            send_frame(half, 12'($urandom), flaw);
            sent++;
        end
    endtask

    initial begin : stimulus
        int quiet;
        int timeout;
        int max_half;
        sb              = new();
        steady          = 1'b0;
        hold_cycles     = 0;
        items_sent      = 0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_QUIET;
        i_cfg_data      <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: clean frames at the extremes, then each flaw but stuck-high
        send_frame(8, 12'h000, FLAW_NONE);
        send_frame(8, 12'hFFF, FLAW_NONE);
        send_frame(3, 12'hA5C, FLAW_NONE);
        send_frame(16, 12'h5A3, FLAW_NONE);
        send_frame(8, 12'($urandom), FLAW_LONG_HALF);
        send_frame(8, 12'($urandom), FLAW_LATE_START2);
        send_frame(8, 12'($urandom), FLAW_NO_MID_EDGE);
        send_frame(6, 12'($urandom), FLAW_STRETCH);
        send_frame(6, 12'($urandom), FLAW_TRUNCATE);
        send_frame(5, 12'($urandom), FLAW_NOISE);
        send_frame(5, 12'($urandom), FLAW_NONE);

        for (int p = 0; p < PLAN_COUNT; p++) begin
            case (p)
                0: begin quiet = 1;   timeout = 400;   max_half = 6;   end
                1: begin quiet = 0;   timeout = 0;     max_half = 0;   end
                2: begin quiet = 0;   timeout = 300;   max_half = 1;   end
                3: begin quiet = 12;  timeout = 1;     max_half = 9;   end
                4: begin quiet = 0;   timeout = 600;   max_half = 10;  end
                5: begin
                    quiet    = $urandom_range(1, 40);
                    timeout  = quiet + 300 + $urandom_range(0, 500);
                    max_half = $urandom_range(4, 20);
                end
                6: begin quiet = 30;  timeout = 900;   max_half = 2;   end
                default: begin quiet = 255; timeout = 65535; max_half = 255; end
            endcase
            settle();
            write_regs(quiet, timeout, max_half);
            if (p == 0) hold_cycles = 300;
            steady = (p == 4);
            // saturated marks: one long frame at the widest half-bit
            if (p == PLAN_COUNT - 1) send_frame(170, 12'($urandom), FLAW_NONE);
            run_random_frames();
        end
        steady = 1'b0;

        i_s_axis_tvalid <= 1'b0;
        while (sb.count_due() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
